FILE: src/pbti_pkg.sv
// Shared constants and types for the pump bank timeout interlock block.
package pbti_pkg;

  // Field widths fixed by the stream words
  localparam int MODE_W        = 2;
  localparam int ID_W          = 3;
  localparam int MASK_OUT_W    = 6;
  localparam int RUNTIME_OUT_W = 32;
  localparam int TIMEOUT_W     = 16;
  localparam int ON_CNT_W      = 16;

  // Stream word layouts
  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = MODE_W;
  localparam int OUT_DATA_W = 48;

  // Word kinds carried on in_tuser; any other code is a query
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  // Interlocked pump pair
  localparam int INTERLOCK_A = 3;
  localparam int INTERLOCK_B = 4;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1800;
  localparam logic [ON_CNT_W-1:0]  ON_SAT        = 16'hFFFF;

  // Per-pump command for one word
  typedef struct packed {
    logic tick;
    logic switch_on;
    logic switch_off;
  } pump_cmd_t;

endpackage

FILE: src/pbti_pump.sv
// One pump lane: on bit, wrapping runtime and saturating on-time watchdog.
module pbti_pump #(
  parameter int RUNTIME_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pbti_pkg::pump_cmd_t              cmd,
  input  logic [pbti_pkg::TIMEOUT_W-1:0]   timeout,
  output logic                             on_nxt,
  output logic [RUNTIME_WIDTH-1:0]         run_nxt,
  output logic                             timed_out
);
  import pbti_pkg::*;

  logic                     on_r;
  logic [RUNTIME_WIDTH-1:0] run_r;
  logic [ON_CNT_W-1:0]      cnt_r;
  logic [ON_CNT_W-1:0]      cnt_nxt;
  logic [ON_CNT_W-1:0]      cnt_inc;

  // Count a tick, trip the watchdog, then apply a switch command
  always_comb begin
    on_nxt    = on_r;
    run_nxt   = run_r;
    cnt_nxt   = cnt_r;
    timed_out = 1'b0;
    cnt_inc   = (cnt_r == ON_SAT) ? cnt_r : cnt_r + ON_CNT_W'(1);
    if (cmd.tick && on_r) begin
      run_nxt = run_r + RUNTIME_WIDTH'(1);
      cnt_nxt = cnt_inc;
      if (cnt_inc > timeout) begin
        on_nxt    = 1'b0;
        timed_out = 1'b1;
      end
    end
    if (cmd.switch_on) begin
      on_nxt  = 1'b1;
      cnt_nxt = '0;
    end else if (cmd.switch_off) begin
      on_nxt = 1'b0;
    end
  end

  // Hold lane state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r  <= 1'b0;
      run_r <= '0;
      cnt_r <= '0;
    end else begin
      on_r  <= on_nxt;
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: src/pump_bank_timeout_interlock_core.sv
// Top level of the pump bank with per-pump run watchdog and 3/4 interlock.
//
// Input channel (in_*): one word per tick, set or query. in_tuser carries the
// word kind; in_tdata carries the pump id and the on/off request.
// Result channel (out_*): exactly one result word per input word, in order:
// the drive bits of all pumps, the pumps tripped by the watchdog on a tick,
// and the on bit and total runtime of the addressed pump, or a bad id flag.
// Configuration: cfg_wr_en writes the watchdog timeout in ticks; write it only
// while no word is in flight.
// Path: an accepted word is held in an input register, all pump lanes are
// updated in parallel when it moves on, and the result is registered before it
// is presented on the result channel.
// Throughput: one word per cycle while out_tready stays high, limited only by
// the single input register and the single result register.
// Reset: all pumps off, runtimes and on-time counts zero, timeout 1800 ticks,
// both stages empty.
// Stall: while out_tready is low the result holds; one more word is taken
// into the input register, then in_tready drops until the result is taken.
module pump_bank_timeout_interlock_core #(
  parameter int PUMP_COUNT    = 6,
  parameter int RUNTIME_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [pbti_pkg::TIMEOUT_W-1:0]     cfg_wr_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [2:0] pump_id, [3] turn_on, [7:4] zero
  input  logic [pbti_pkg::IN_DATA_W-1:0]     in_tdata,
  // [1:0] mode
  input  logic [pbti_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [5:0] pump_outputs, [11:6] timed_out_mask, [12] selected_on,
  // [44:13] selected_runtime, [45] bad_id, [47:46] zero
  output logic [pbti_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import pbti_pkg::*;

  localparam int IDX_W = $clog2(PUMP_COUNT);

  logic [TIMEOUT_W-1:0]     timeout_r;

  logic                     s1_valid_r;
  logic [MODE_W-1:0]        s1_mode_r;
  logic [ID_W-1:0]          s1_id_r;
  logic                     s1_turn_on_r;

  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;
  logic [OUT_DATA_W-1:0]    out_data_nxt;

  logic                     in_fire;
  logic                     s1_fire;
  logic                     out_advance;
  logic                     id_valid;
  logic [IDX_W-1:0]         idx;
  logic                     do_tick;
  logic                     do_set;

  pump_cmd_t                cmd       [PUMP_COUNT];
  logic [RUNTIME_WIDTH-1:0] run_nxt   [PUMP_COUNT];
  logic [PUMP_COUNT-1:0]    on_nxt;
  logic [PUMP_COUNT-1:0]    timed_out;

  logic [MASK_OUT_W-1:0]    pump_bits;
  logic [MASK_OUT_W-1:0]    trip_bits;
  logic                     sel_on;
  logic [RUNTIME_WIDTH-1:0] sel_run;
  logic [RUNTIME_OUT_W-1:0] sel_run_out;

  // Handshake: input register moves when the result register is free
  assign out_advance = !out_valid_r || out_tready;
  assign s1_fire     = s1_valid_r && out_advance;
  assign in_tready   = !s1_valid_r || out_advance;
  assign in_fire     = in_tvalid && in_tready;

  // Hold the watchdog timeout
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r    <= in_tuser[MODE_W-1:0];
      s1_id_r      <= in_tdata[ID_W-1:0];
      s1_turn_on_r <= in_tdata[ID_W];
    end
  end

  // Decode the word into per-pump commands
  assign id_valid = 32'(s1_id_r) < PUMP_COUNT;
  assign idx      = IDX_W'(s1_id_r);
  assign do_tick  = s1_fire && (s1_mode_r == MODE_TICK);
  assign do_set   = s1_fire && (s1_mode_r == MODE_SET) && id_valid;

  for (genvar i = 0; i < PUMP_COUNT; i++) begin : g_pump
    localparam int PARTNER = (i == INTERLOCK_A) ? INTERLOCK_B :
                             (i == INTERLOCK_B) ? INTERLOCK_A : i;
    localparam bit HAS_PARTNER = (i == INTERLOCK_A) || (i == INTERLOCK_B);

    logic hit;
    logic partner_hit;

    assign hit         = (idx == IDX_W'(i));
    assign partner_hit = HAS_PARTNER && (idx == IDX_W'(PARTNER));

    always_comb begin
      cmd[i].tick       = do_tick;
      cmd[i].switch_on  = do_set && s1_turn_on_r && hit;
      cmd[i].switch_off = do_set && ((!s1_turn_on_r && hit) ||
                                     (s1_turn_on_r && partner_hit));
    end

    pbti_pump #(
      .RUNTIME_WIDTH (RUNTIME_WIDTH)
    ) u_pump (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd[i]),
      .timeout   (timeout_r),
      .on_nxt    (on_nxt[i]),
      .run_nxt   (run_nxt[i]),
      .timed_out (timed_out[i])
    );
  end

  // Fit the bank masks to the result fields
  for (genvar j = 0; j < MASK_OUT_W; j++) begin : g_mask
    if (j < PUMP_COUNT) begin : g_bit
      assign pump_bits[j] = on_nxt[j];
      assign trip_bits[j] = timed_out[j];
    end else begin : g_pad
      assign pump_bits[j] = 1'b0;
      assign trip_bits[j] = 1'b0;
    end
  end

  // Select the addressed pump
  assign sel_on  = id_valid ? on_nxt[idx] : 1'b0;
  assign sel_run = id_valid ? run_nxt[idx] : '0;

  if (RUNTIME_WIDTH >= RUNTIME_OUT_W) begin : g_run_trunc
    assign sel_run_out = sel_run[RUNTIME_OUT_W-1:0];
  end else begin : g_run_ext
    assign sel_run_out = {{(RUNTIME_OUT_W-RUNTIME_WIDTH){1'b0}}, sel_run};
  end

  assign out_data_nxt = {2'b00, !id_valid, sel_run_out, sel_on, trip_bits, pump_bits};

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Interlocked pumps never run together
  a_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    !(on_nxt[INTERLOCK_A] && on_nxt[INTERLOCK_B]))
    else $error("interlocked pumps both on");

  // A tripped pump is reported off in the same word
  a_trip_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r[11:6] & out_data_r[5:0]) == '0))
    else $error("tripped pump still driven");

  // Only a tick can trip the watchdog
  a_trip_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (timed_out != '0) |-> (s1_fire && (s1_mode_r == MODE_TICK)))
    else $error("watchdog trip outside a tick");

  // A bad id reports an empty selection
  a_bad_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[45]) |-> (out_data_r[44:12] == '0))
    else $error("bad id with nonzero selection");

  // Every accepted word yields a result the next cycle it can move
  a_s1_drain: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("result word lost");

endmodule
